FILE: hdl/pfs_pkg.sv
`default_nettype none

package pfs_pkg;

  localparam int VOLT_W      = 24;
  localparam int TEMP_W      = 16;
  localparam int TIME_W      = 48;
  localparam int CMD_W       = 2;
  localparam int FIDX_W      = 5;
  localparam int FAULT_OUT_W = 20;
  localparam int COUNT_W     = 5;
  localparam int ACT_W       = 6;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 24;

  // commands
  localparam logic [CMD_W-1:0] CMD_ANALYZE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET       = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NO_BATTERY   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NETWORK_MIN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NETWORK_MAX  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONV_MIN     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONV_MAX     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BAT_FAULT_MIN = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BAT_FAULT_MAX = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RADIATOR_TRIP = 4'd7;

  // fault numbers handled by the sample checks
  localparam int FLT_NO_BATTERY  = 0;
  localparam int FLT_NET_LOW     = 6;
  localparam int FLT_NET_HIGH    = 7;
  localparam int FLT_CONV_LOW    = 8;
  localparam int FLT_CONV_HIGH   = 9;
  localparam int FLT_BAT_LOW     = 10;
  localparam int FLT_BAT_HIGH    = 11;
  localparam int FLT_MODE_CANCEL = 15;
  localparam int FLT_OVERHEAT    = 18;
  localparam int FLT_SENSOR_OPEN = 19;
  localparam int NUM_ACT_FAULTS  = 20;

  localparam logic signed [TEMP_W-1:0] SENSOR_OPEN_TEMP = -16'sd15000;

  // action masks: b0 stop charge, b1 stop discharge, b2 conv off,
  // b3 payload off, b4 pause charge, b5 pause discharge
  localparam logic [ACT_W-1:0] ACT_ALL_STOP = 6'h0F;
  localparam logic [ACT_W-1:0] ACT_DIS_STOP = 6'h0A;
  localparam logic [ACT_W-1:0] ACT_HEAT     = 6'h3C;
  localparam logic [ACT_W-1:0] ACT_NONE     = 6'h00;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [VOLT_W-1:0] battery_volts;
    logic signed [VOLT_W-1:0] network_volts;
    logic signed [VOLT_W-1:0] converter_volts;
    logic signed [TEMP_W-1:0] radiator_temp;
    logic                     precharge_on;
    logic                     contactor_on;
    logic [TIME_W-1:0]        time_now;
    logic [FIDX_W-1:0]        fault_index;
  } pfs_in_t;

  typedef struct packed {
    logic [FAULT_OUT_W-1:0] fault_bits;
    logic [COUNT_W-1:0]     fault_count;
    logic [ACT_W-1:0]       action_mask;
    logic                   led_pulse;
  } pfs_out_t;

  typedef struct packed {
    logic signed [VOLT_W-1:0] no_battery_level;
    logic signed [VOLT_W-1:0] network_min;
    logic signed [VOLT_W-1:0] network_max;
    logic signed [VOLT_W-1:0] converter_min;
    logic signed [VOLT_W-1:0] converter_max;
    logic signed [VOLT_W-1:0] battery_fault_min;
    logic signed [VOLT_W-1:0] battery_fault_max;
    logic signed [TEMP_W-1:0] radiator_trip_temp;
  } pfs_cfg_t;

  function automatic logic [ACT_W-1:0] act_of(input int n);
    logic [ACT_W-1:0] a;
    case (n)
      2, 3, 5: a = ACT_DIS_STOP;
      18:      a = ACT_HEAT;
      19:      a = ACT_NONE;
      default: a = ACT_ALL_STOP;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pfs_chan_if.sv
`default_nettype none

interface pfs_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/pfs_cfg_regs.sv
`default_nettype none

module pfs_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [pfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pfs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pfs_pkg::pfs_cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.no_battery_level   <= 24'sd0;
      cfg.network_min        <= 24'sd0;
      cfg.network_max        <= 24'sh7FFFFF;
      cfg.converter_min      <= 24'sd0;
      cfg.converter_max      <= 24'sh7FFFFF;
      cfg.battery_fault_min  <= 24'sd0;
      cfg.battery_fault_max  <= 24'sh7FFFFF;
      cfg.radiator_trip_temp <= 16'sd8000;
    end else if (cfg_we) begin
      case (cfg_index)
        pfs_pkg::REG_NO_BATTERY:    cfg.no_battery_level   <= cfg_data;
        pfs_pkg::REG_NETWORK_MIN:   cfg.network_min        <= cfg_data;
        pfs_pkg::REG_NETWORK_MAX:   cfg.network_max        <= cfg_data;
        pfs_pkg::REG_CONV_MIN:      cfg.converter_min      <= cfg_data;
        pfs_pkg::REG_CONV_MAX:      cfg.converter_max      <= cfg_data;
        pfs_pkg::REG_BAT_FAULT_MIN: cfg.battery_fault_min  <= cfg_data;
        pfs_pkg::REG_BAT_FAULT_MAX: cfg.battery_fault_max  <= cfg_data;
        pfs_pkg::REG_RADIATOR_TRIP: cfg.radiator_trip_temp <= cfg_data[pfs_pkg::TEMP_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pfs_check.sv
`default_nettype none

module pfs_check #(
  parameter int              NUM_FAULTS    = 20,
  parameter longint unsigned CONFIRM_TICKS = 96000000,
  parameter int              RESUME_TEMP   = 6000
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire pfs_pkg::pfs_in_t      item,
  input  wire pfs_pkg::pfs_cfg_t     cfg,
  output logic [NUM_FAULTS-1:0]      flags_next
);

  localparam logic [pfs_pkg::TIME_W-1:0] CONFIRM = pfs_pkg::TIME_W'(CONFIRM_TICKS);
  localparam logic signed [pfs_pkg::TEMP_W-1:0] RESUME = pfs_pkg::TEMP_W'(RESUME_TEMP);

  logic [NUM_FAULTS-1:0]       flags;
  logic [NUM_FAULTS-1:0]       sel;
  logic [pfs_pkg::TIME_W-1:0]  net_low_since, net_high_since;
  logic [pfs_pkg::TIME_W-1:0]  conv_low_since, conv_high_since;
  logic                        net_ok_low, net_ok_high, conv_ok_low, conv_ok_high;
  logic                        cf_net_low, cf_net_high, cf_conv_low, cf_conv_high;
  logic                        may_clear, analyze;

  // in-range tests; a stamp follows time_now while its voltage is in range
  assign net_ok_low   = item.network_volts > cfg.network_min;
  assign net_ok_high  = item.network_volts < cfg.network_max;
  assign conv_ok_low  = item.converter_volts > cfg.converter_min;
  assign conv_ok_high = item.converter_volts < cfg.converter_max;

  // elapsed ticks wrap modulo 2^48
  assign cf_net_low   = (item.time_now - net_low_since) >= CONFIRM;
  assign cf_net_high  = (item.time_now - net_high_since) >= CONFIRM;
  assign cf_conv_low  = (item.time_now - conv_low_since) >= CONFIRM;
  assign cf_conv_high = (item.time_now - conv_high_since) >= CONFIRM;

  assign may_clear = !flags[pfs_pkg::FLT_MODE_CANCEL];
  assign analyze   = item.cmd == pfs_pkg::CMD_ANALYZE;

  always_comb begin
    for (int n = 0; n < NUM_FAULTS; n++) begin
      sel[n] = item.fault_index == pfs_pkg::FIDX_W'(n);
    end
  end

  always_comb begin
    flags_next = flags;
    case (item.cmd)
      pfs_pkg::CMD_ANALYZE: begin
        if (item.battery_volts < cfg.no_battery_level) begin
          if (item.precharge_on) flags_next[pfs_pkg::FLT_NO_BATTERY] = 1'b1;
        end else if (may_clear) begin
          flags_next[pfs_pkg::FLT_NO_BATTERY] = 1'b0;
        end

        if (net_ok_low) begin
          if (may_clear) flags_next[pfs_pkg::FLT_NET_LOW] = 1'b0;
        end else if (cf_net_low) begin
          flags_next[pfs_pkg::FLT_NET_LOW] = 1'b1;
        end

        if (net_ok_high) begin
          if (may_clear) flags_next[pfs_pkg::FLT_NET_HIGH] = 1'b0;
        end else if (cf_net_high) begin
          flags_next[pfs_pkg::FLT_NET_HIGH] = 1'b1;
        end

        if (conv_ok_low) begin
          if (may_clear) flags_next[pfs_pkg::FLT_CONV_LOW] = 1'b0;
        end else if (cf_conv_low) begin
          flags_next[pfs_pkg::FLT_CONV_LOW] = 1'b1;
        end

        if (conv_ok_high) begin
          if (may_clear) flags_next[pfs_pkg::FLT_CONV_HIGH] = 1'b0;
        end else if (cf_conv_high) begin
          flags_next[pfs_pkg::FLT_CONV_HIGH] = 1'b1;
        end

        if (item.battery_volts < cfg.battery_fault_min) begin
          if (item.contactor_on) flags_next[pfs_pkg::FLT_BAT_LOW] = 1'b1;
        end else if (may_clear) begin
          flags_next[pfs_pkg::FLT_BAT_LOW] = 1'b0;
        end

        if (item.battery_volts > cfg.battery_fault_max) begin
          flags_next[pfs_pkg::FLT_BAT_HIGH] = 1'b1;
        end else if (may_clear) begin
          flags_next[pfs_pkg::FLT_BAT_HIGH] = 1'b0;
        end

        // overheat with resume hysteresis, never held by mode cancel
        if (item.radiator_temp > cfg.radiator_trip_temp) begin
          flags_next[pfs_pkg::FLT_OVERHEAT] = 1'b1;
        end else if (item.radiator_temp < RESUME) begin
          flags_next[pfs_pkg::FLT_OVERHEAT] = 1'b0;
        end

        flags_next[pfs_pkg::FLT_SENSOR_OPEN] = item.radiator_temp < pfs_pkg::SENSOR_OPEN_TEMP;
      end
      pfs_pkg::CMD_SET:       flags_next = flags | sel;
      pfs_pkg::CMD_CLEAR:     flags_next = flags & ~sel;
      pfs_pkg::CMD_CLEAR_ALL: flags_next = '0;
      default:                flags_next = flags;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags           <= '0;
      net_low_since   <= '0;
      net_high_since  <= '0;
      conv_low_since  <= '0;
      conv_high_since <= '0;
    end else if (en) begin
      flags <= flags_next;
      if (analyze) begin
        if (net_ok_low)   net_low_since   <= item.time_now;
        if (net_ok_high)  net_high_since  <= item.time_now;
        if (conv_ok_low)  conv_low_since  <= item.time_now;
        if (conv_ok_high) conv_high_since <= item.time_now;
      end
    end
  end

`ifndef SYNTHESIS
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(flags))
    else $error("fault flags changed with no beat in the check stage");

  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    (en && item.cmd == pfs_pkg::CMD_CLEAR_ALL) |=> (flags == '0))
    else $error("clear all left a fault standing");

  a_stamp_hold: assert property (@(posedge clk) disable iff (rst)
    !(en && analyze) |=> ($stable(net_low_since) && $stable(conv_high_since)))
    else $error("confirmation stamp moved outside an analyse beat");
`endif

endmodule

`default_nettype wire

FILE: hdl/pfs_summary.sv
`default_nettype none

module pfs_summary #(
  parameter int NUM_FAULTS = 20
) (
  input  wire logic [NUM_FAULTS-1:0] flags,
  output pfs_pkg::pfs_out_t          summary
);

  localparam int CNT_W = $clog2(NUM_FAULTS + 1);

  logic [CNT_W-1:0]              cnt;
  logic [pfs_pkg::ACT_W-1:0]     acts;

  always_comb begin
    cnt  = '0;
    acts = '0;
    for (int n = 0; n < NUM_FAULTS; n++) begin
      cnt = cnt + CNT_W'(flags[n]);
      if (n < pfs_pkg::NUM_ACT_FAULTS && flags[n]) acts = acts | pfs_pkg::act_of(n);
    end
  end

  always_comb begin
    summary.fault_bits  = flags[pfs_pkg::FAULT_OUT_W-1:0];
    summary.fault_count = cnt[pfs_pkg::COUNT_W-1:0];
    summary.action_mask = acts;
    summary.led_pulse   = |flags;
  end

endmodule

`default_nettype wire

FILE: hdl/power_fault_supervisor.sv
`default_nettype none

// Channel   Dir  Payload              Beat taken when
// item      in   pfs_pkg::pfs_in_t    item.valid && item.ready
// result    out  pfs_pkg::pfs_out_t   result.valid && result.ready
// cfg_*     in   index + 24b data     cfg_we (no back-pressure)
//
// One beat in and one beat out per clock unless a result is held by the sink;
// each item passes the input reg, then fault state + flag reg, then result reg.
// The check stage registers its fault state with the flag register, so it never holds the next item back.
// The whole pipe stalls together while a result is held by the sink.
// rst (synchronous) clears valids, all faults, the four stamps and reloads
// the threshold registers with their reset values.

module power_fault_supervisor #(
  parameter int              NUM_FAULTS    = 20,
  parameter longint unsigned CONFIRM_TICKS = 96000000,
  parameter int              RESUME_TEMP   = 6000
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pfs_pkg::CFG_DATA_W-1:0] cfg_data,
  pfs_chan_if.sink                            item,
  pfs_chan_if.source                          result
);

  pfs_pkg::pfs_cfg_t     cfg;
  pfs_pkg::pfs_in_t      s1_item;
  pfs_pkg::pfs_out_t     summary;
  logic                  s1_valid;
  logic                  s2_valid;
  logic [NUM_FAULTS-1:0] s2_flags;
  logic [NUM_FAULTS-1:0] flags_next;
  logic                  adv;

  // everything moves unless a finished result is still waiting
  assign adv        = !result.valid || result.ready;
  assign item.ready = adv;

  pfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && item.valid) begin
      s1_item <= item.data;
    end
  end

  // stage 2: fault state update, new flags captured for the summary
  pfs_check #(
    .NUM_FAULTS    (NUM_FAULTS),
    .CONFIRM_TICKS (CONFIRM_TICKS),
    .RESUME_TEMP   (RESUME_TEMP)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .en         (adv && s1_valid),
    .item       (s1_item),
    .cfg        (cfg),
    .flags_next (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_flags <= flags_next;
    end
  end

  // stage 3: count, action mask and lamp into the result register
  pfs_summary #(
    .NUM_FAULTS (NUM_FAULTS)
  ) u_summary (
    .flags   (s2_flags),
    .summary (summary)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      result.data <= summary;
    end
  end

`ifndef SYNTHESIS
  a_lamp_bits: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.data.fault_bits != '0) |-> result.data.led_pulse)
    else $error("lamp off with faults standing");

  a_lamp_acts: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.data.action_mask != '0) |-> result.data.led_pulse)
    else $error("actions requested with lamp off");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_item)))
    else $error("input stage lost its beat during a stall");

  a_s2_feed: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_valid) |=> s2_valid)
    else $error("check stage beat did not reach the flag register");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pfs_pkg::*;

  // Block parameters, passed to the instance so that both sides agree
  localparam int              NUM_FAULTS    = 20;
  localparam longint unsigned CONFIRM_TICKS = 96000000;
  localparam int              RESUME_TEMP   = 6000;

  // Worst case per beat is the longest idle plus the longest stall plus the pipe;
  // about 1000 beats plus register phases stay well under this.
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_IDLE    = 17;

  // Register slot beyond the last one: writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd12;

  // Fault numbers not named in the package
  localparam int FLT_PAYLOAD_LOCKING = 2;
  localparam int FLT_PAYLOAD_LOCKED  = 3;
  localparam int FLT_PAYLOAD_SHORT   = 5;

  localparam logic signed [VOLT_W-1:0] VOLT_LO = 24'sh800000;
  localparam logic signed [VOLT_W-1:0] VOLT_HI = 24'sh7FFFFF;
  localparam logic signed [TEMP_W-1:0] TEMP_LO = 16'sh8000;
  localparam logic signed [TEMP_W-1:0] TEMP_HI = 16'sh7FFF;

  // Bench thresholds: a plausible charger set-up used for the directed beats
  localparam pfs_cfg_t BENCH_CFG = '{24'sd1000000, 24'sd2000000, 24'sd3000000,
                                     24'sd1500000, 24'sd4000000, 24'sd1200000,
                                     24'sd5000000, 16'sd7000};
  localparam pfs_cfg_t RESET_CFG = '{24'sd0, 24'sd0, VOLT_HI, 24'sd0, VOLT_HI,
                                     24'sd0, VOLT_HI, 16'sd8000};
  localparam pfs_cfg_t FLOOR_CFG = '{VOLT_LO, VOLT_LO, VOLT_LO, VOLT_LO, VOLT_LO,
                                     VOLT_LO, VOLT_LO, TEMP_LO};
  localparam pfs_cfg_t CEIL_CFG  = '{VOLT_HI, VOLT_HI, VOLT_HI, VOLT_HI, VOLT_HI,
                                     VOLT_HI, VOLT_HI, TEMP_HI};

  // Healthy readings under BENCH_CFG
  localparam int NOM_BAT  = 3000000;
  localparam int NOM_NET  = 2500000;
  localparam int NOM_CONV = 2500000;
  localparam int NOM_TEMP = 2500;

  // Tracks fault state from accepted beats and checks status beats in order.
  class fault_scoreboard;
    pfs_cfg_t              cfg;
    logic [NUM_FAULTS-1:0] flags;
    logic [TIME_W-1:0]     net_low_t, net_high_t, conv_low_t, conv_high_t;
    logic [ACT_W-1:0]      fault_act[NUM_FAULTS];
    pfs_out_t              status_due[$];
    int                    errors, checked, confirms, held_samples;

    function new();
      cfg = RESET_CFG;
      flags = '0;
      net_low_t = '0;
      net_high_t = '0;
      conv_low_t = '0;
      conv_high_t = '0;
      foreach (fault_act[n]) fault_act[n] = ACT_ALL_STOP;
      fault_act[FLT_PAYLOAD_LOCKING] = ACT_DIS_STOP;
      fault_act[FLT_PAYLOAD_LOCKED]  = ACT_DIS_STOP;
      fault_act[FLT_PAYLOAD_SHORT]   = ACT_DIS_STOP;
      fault_act[FLT_OVERHEAT]        = ACT_HEAT;
      fault_act[FLT_SENSOR_OPEN]     = ACT_NONE;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_NO_BATTERY:    cfg.no_battery_level   = d;
        REG_NETWORK_MIN:   cfg.network_min        = d;
        REG_NETWORK_MAX:   cfg.network_max        = d;
        REG_CONV_MIN:      cfg.converter_min      = d;
        REG_CONV_MAX:      cfg.converter_max      = d;
        REG_BAT_FAULT_MIN: cfg.battery_fault_min  = d;
        REG_BAT_FAULT_MAX: cfg.battery_fault_max  = d;
        REG_RADIATOR_TRIP: cfg.radiator_trip_temp = d[TEMP_W-1:0];
        default: ;
      endcase
    endfunction

    // out of range for the whole confirmation window (48-bit wrap)
    function bit aged(logic [TIME_W-1:0] now, logic [TIME_W-1:0] since);
      logic [TIME_W-1:0] el;
      el = now - since;
      return el >= CONFIRM_TICKS;
    endfunction

    function void take_command(pfs_in_t it);
      logic [NUM_FAULTS-1:0]      f;
      logic signed [VOLT_W-1:0]   bat, net, conv;
      logic signed [TEMP_W-1:0]   temp;
      logic [TIME_W-1:0]          now;
      bit                         hold;
      int                         cnt;
      pfs_out_t                   s;
      f = flags;
      bat = it.battery_volts;
      net = it.network_volts;
      conv = it.converter_volts;
      temp = it.radiator_temp;
      now = it.time_now;
      case (it.cmd)
        CMD_ANALYZE: begin
          // mode cancel freezes the clearing of the voltage checks
          hold = f[FLT_MODE_CANCEL];
          if (hold) held_samples++;
          if (bat < $signed(cfg.no_battery_level)) begin
            if (it.precharge_on) f[FLT_NO_BATTERY] = 1'b1;
          end else if (!hold) begin
            f[FLT_NO_BATTERY] = 1'b0;
          end
          if (net > $signed(cfg.network_min)) begin
            net_low_t = now;
            if (!hold) f[FLT_NET_LOW] = 1'b0;
          end else if (aged(now, net_low_t)) begin
            if (!f[FLT_NET_LOW]) confirms++;
            f[FLT_NET_LOW] = 1'b1;
          end
          if (net < $signed(cfg.network_max)) begin
            net_high_t = now;
            if (!hold) f[FLT_NET_HIGH] = 1'b0;
          end else if (aged(now, net_high_t)) begin
            if (!f[FLT_NET_HIGH]) confirms++;
            f[FLT_NET_HIGH] = 1'b1;
          end
          if (conv > $signed(cfg.converter_min)) begin
            conv_low_t = now;
            if (!hold) f[FLT_CONV_LOW] = 1'b0;
          end else if (aged(now, conv_low_t)) begin
            if (!f[FLT_CONV_LOW]) confirms++;
            f[FLT_CONV_LOW] = 1'b1;
          end
          if (conv < $signed(cfg.converter_max)) begin
            conv_high_t = now;
            if (!hold) f[FLT_CONV_HIGH] = 1'b0;
          end else if (aged(now, conv_high_t)) begin
            if (!f[FLT_CONV_HIGH]) confirms++;
            f[FLT_CONV_HIGH] = 1'b1;
          end
          if (bat < $signed(cfg.battery_fault_min)) begin
            if (it.contactor_on) f[FLT_BAT_LOW] = 1'b1;
          end else if (!hold) begin
            f[FLT_BAT_LOW] = 1'b0;
          end
          if (bat > $signed(cfg.battery_fault_max)) f[FLT_BAT_HIGH] = 1'b1;
          else if (!hold) f[FLT_BAT_HIGH] = 1'b0;
          // overheat holds between resume and trip
          if (temp > $signed(cfg.radiator_trip_temp)) f[FLT_OVERHEAT] = 1'b1;
          else if (temp < RESUME_TEMP) f[FLT_OVERHEAT] = 1'b0;
          f[FLT_SENSOR_OPEN] = temp < SENSOR_OPEN_TEMP;
        end
        CMD_SET:   if (it.fault_index < NUM_FAULTS) f[it.fault_index] = 1'b1;
        CMD_CLEAR: if (it.fault_index < NUM_FAULTS) f[it.fault_index] = 1'b0;
        default:   f = '0;
      endcase
      flags = f;
      cnt = 0;
      s.action_mask = '0;
      for (int n = 0; n < NUM_FAULTS; n++) begin
        if (f[n]) begin
          cnt++;
          s.action_mask = s.action_mask | fault_act[n];
        end
      end
      s.fault_bits = f;
      s.fault_count = COUNT_W'(cnt);
      s.led_pulse = |f;
      status_due.push_back(s);
    endfunction

    function void check_status(pfs_out_t got);
      pfs_out_t want;
      if (status_due.size() == 0) begin
        $error("status beat with none outstanding: %h", got);
        errors++;
        return;
      end
      want = status_due.pop_front();
      checked++;
      if (got.fault_bits !== want.fault_bits) begin
        $error("fault_bits: expected %h, got %h", want.fault_bits, got.fault_bits);
        errors++;
      end
      if (got.fault_count !== want.fault_count) begin
        $error("fault_count: expected %0d, got %0d", want.fault_count, got.fault_count);
        errors++;
      end
      if (got.action_mask !== want.action_mask) begin
        $error("action_mask: expected %h, got %h", want.action_mask, got.action_mask);
        errors++;
      end
      if (got.led_pulse !== want.led_pulse) begin
        $error("led_pulse: expected %b, got %b", want.led_pulse, got.led_pulse);
        errors++;
      end
    endfunction

    function int pending();
      return status_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pfs_chan_if #(.T(pfs_in_t))  item_ch ();
  pfs_chan_if #(.T(pfs_out_t)) result_ch ();

  power_fault_supervisor #(
    .NUM_FAULTS    (NUM_FAULTS),
    .CONFIRM_TICKS (CONFIRM_TICKS),
    .RESUME_TEMP   (RESUME_TEMP)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  fault_scoreboard sb = new();

  bit                       calm = 1'b0;   // no idling on either side
  int                       cycle_count = 0;
  int                       settings_used = 1;
  logic [TIME_W-1:0]        tick = '0;     // running tick counter for samples
  logic signed [VOLT_W-1:0] last_net = '0;
  logic signed [VOLT_W-1:0] last_conv = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("no progress after %0d cycles, %0d status beats outstanding",
             cycle_count, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Beat monitor: values seen here are those from before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (item_ch.valid && item_ch.ready) sb.take_command(item_ch.data);
      if (result_ch.valid && result_ch.ready) sb.check_status(result_ch.data);
    end
  end

  // Status sink: random stall before each beat, none during calm stretches.
  // With no stall ready is simply left high.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
      repeat (stall) begin
        @(negedge clk);
        result_ch.ready = 1'b0;
      end
      @(negedge clk);
      result_ch.ready = 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // One command beat: optional idle, then hold until taken
  task automatic send_item(input pfs_in_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
    repeat (gap) begin
      @(negedge clk);
      item_ch.valid = 1'b0;
    end
    @(negedge clk);
    item_ch.valid = 1'b1;
    item_ch.data = it;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic drive_sample(input logic [CMD_W-1:0] c, input int idx,
                              input int bat, input int net, input int conv,
                              input int temp, input bit pre, input bit con,
                              input logic [TIME_W-1:0] t);
    pfs_in_t it;
    it.cmd = c;
    it.fault_index = FIDX_W'(idx);
    it.battery_volts = VOLT_W'(bat);
    it.network_volts = VOLT_W'(net);
    it.converter_volts = VOLT_W'(conv);
    it.radiator_temp = TEMP_W'(temp);
    it.precharge_on = pre;
    it.contactor_on = con;
    it.time_now = t;
    send_item(it);
  endtask

  // Stop sending and let every outstanding status beat come back
  task automatic drain();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg_port(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    sb.write_reg(idx, d);
  endtask

  // Only called with the pipe empty
  task automatic load_settings(input pfs_cfg_t c);
    write_reg_port(REG_NO_BATTERY, c.no_battery_level);
    write_reg_port(REG_NETWORK_MIN, c.network_min);
    write_reg_port(REG_NETWORK_MAX, c.network_max);
    write_reg_port(REG_CONV_MIN, c.converter_min);
    write_reg_port(REG_CONV_MAX, c.converter_max);
    write_reg_port(REG_BAT_FAULT_MIN, c.battery_fault_min);
    write_reg_port(REG_BAT_FAULT_MAX, c.battery_fault_max);
    // upper data bits are junk: only the low 16 belong to the trip level
    write_reg_port(REG_RADIATOR_TRIP, {8'($urandom), c.radiator_trip_temp});
    write_reg_port(REG_SPARE, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  function automatic pfs_cfg_t random_settings();
    pfs_cfg_t c;
    c.no_battery_level = VOLT_W'($urandom);
    c.network_min = VOLT_W'($urandom);
    c.network_max = VOLT_W'($urandom);
    c.converter_min = VOLT_W'($urandom);
    c.converter_max = VOLT_W'($urandom);
    c.battery_fault_min = VOLT_W'($urandom);
    c.battery_fault_max = VOLT_W'($urandom);
    c.radiator_trip_temp = TEMP_W'($urandom);
    return c;
  endfunction

  // Reading near one of two thresholds, at a rail, or anywhere
  function automatic logic signed [VOLT_W-1:0] near_volt(
      input logic signed [VOLT_W-1:0] lo, input logic signed [VOLT_W-1:0] hi);
    int d;
    logic signed [VOLT_W-1:0] v;
    d = int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 9))
      0, 1, 2: v = VOLT_W'(lo + d);
      3, 4, 5: v = VOLT_W'(hi + d);
      6:       v = VOLT_LO;
      7:       v = VOLT_HI;
      default: v = VOLT_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic pfs_in_t random_item();
    pfs_in_t it;
    int      pick, d;
    // ticks mostly creep forward; often a whole confirmation window
    // (give or take two) passes; sometimes the counter jumps or runs back
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: tick = tick + TIME_W'($urandom_range(0, 1000));
      10, 11, 12, 13, 14:
        tick = tick + TIME_W'(CONFIRM_TICKS) - 2 + TIME_W'($urandom_range(0, 4));
      15, 16:  tick = TIME_W'({$urandom, $urandom});
      17:      tick = tick - TIME_W'($urandom_range(1, 1000));
      default: ;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 75)      it.cmd = CMD_ANALYZE;
    else if (pick < 86) it.cmd = CMD_SET;
    else if (pick < 96) it.cmd = CMD_CLEAR;
    else                it.cmd = CMD_CLEAR_ALL;
    // network and converter readings persist half the time so that
    // out-of-range spells last long enough to be confirmed
    if ($urandom_range(0, 1) == 0) last_net = near_volt(sb.cfg.network_min, sb.cfg.network_max);
    if ($urandom_range(0, 1) == 0)
      last_conv = near_volt(sb.cfg.converter_min, sb.cfg.converter_max);
    it.network_volts = last_net;
    it.converter_volts = last_conv;
    it.battery_volts = near_volt($urandom_range(0, 1) ? sb.cfg.no_battery_level
                                                      : sb.cfg.battery_fault_min,
                                 sb.cfg.battery_fault_max);
    d = int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 7))
      0, 1:    it.radiator_temp = TEMP_W'(sb.cfg.radiator_trip_temp + d);
      2, 3:    it.radiator_temp = TEMP_W'(RESUME_TEMP + d);
      4:       it.radiator_temp = TEMP_W'(SENSOR_OPEN_TEMP + d);
      5:       it.radiator_temp = $urandom_range(0, 1) ? TEMP_LO : TEMP_HI;
      default: it.radiator_temp = TEMP_W'($urandom);
    endcase
    it.precharge_on = 1'($urandom_range(0, 1));
    it.contactor_on = 1'($urandom_range(0, 1));
    it.time_now = tick;
    pick = $urandom_range(0, 29);
    if (pick == 0)     it.fault_index = FIDX_W'($urandom_range(NUM_FAULTS, 31));
    else if (pick < 5) it.fault_index = FIDX_W'(FLT_MODE_CANCEL);
    else               it.fault_index = FIDX_W'($urandom_range(0, NUM_FAULTS - 1));
    return it;
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      // stretches of back-to-back traffic now and then
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      send_item(random_item());
    end
  endtask

  initial begin
    logic [TIME_W-1:0] t;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Thresholds as they come out of reset
    run_random(100);
    drain();

    // Directed beats on the bench thresholds
    load_settings(BENCH_CFG);
    t = 48'd1000;
    drive_sample(CMD_ANALYZE, 0, NOM_BAT, NOM_NET, NOM_CONV, NOM_TEMP, 0, 0, t);
    // battery missing only counts with precharge on
    t = t + 1;
    drive_sample(CMD_ANALYZE, 0, 500000, NOM_NET, NOM_CONV, NOM_TEMP, 1, 0, t);
    // low battery only counts with the contactor on; missing battery holds
    t = t + 1;
    drive_sample(CMD_ANALYZE, 0, 500000, NOM_NET, NOM_CONV, NOM_TEMP, 0, 1, t);
    t = t + 1;
    drive_sample(CMD_ANALYZE, 0, VOLT_HI, NOM_NET, NOM_CONV, NOM_TEMP, 0, 1, t);
    // network at its minimum, converter at its maximum: one tick short,
    // then exactly the confirmation window
    t = t + TIME_W'(CONFIRM_TICKS) - 1;
    drive_sample(CMD_ANALYZE, 0, NOM_BAT, 2000000, 4000000, NOM_TEMP, 0, 0, t);
    t = t + 1;
    drive_sample(CMD_ANALYZE, 0, NOM_BAT, 2000000, 4000000, NOM_TEMP, 0, 0, t);
    t = t + 1;
    drive_sample(CMD_ANALYZE, 0, VOLT_LO, VOLT_LO, VOLT_HI, NOM_TEMP, 1, 1, t);
    // swap sides: network at max, converter at min
    t = t + TIME_W'(CONFIRM_TICKS);
    drive_sample(CMD_ANALYZE, 0, NOM_BAT, 3000000, 1500000, NOM_TEMP, 0, 0, t);
    // radiator trip, hysteresis band, resume, sensor open
    t = t + 1;
    drive_sample(CMD_ANALYZE, 0, NOM_BAT, 3000000, 1500000, TEMP_HI, 0, 0, t);
    drive_sample(CMD_ANALYZE, 0, NOM_BAT, 3000000, 1500000, RESUME_TEMP, 0, 0, t);
    drive_sample(CMD_ANALYZE, 0, NOM_BAT, 3000000, 1500000, RESUME_TEMP - 1, 0, 0, t);
    drive_sample(CMD_ANALYZE, 0, NOM_BAT, 3000000, 1500000, -15001, 0, 0, t);
    drive_sample(CMD_ANALYZE, 0, NOM_BAT, 3000000, 1500000, -15000, 0, 0, t);
    drive_sample(CMD_ANALYZE, 0, NOM_BAT, 3000000, 1500000, TEMP_LO, 0, 0, t);
    // mode cancel: voltage faults stay, low battery can still be raised,
    // sensor fault still follows the temperature
    drive_sample(CMD_SET, FLT_MODE_CANCEL, NOM_BAT, NOM_NET, NOM_CONV, NOM_TEMP, 0, 0, t);
    t = t + 1;
    drive_sample(CMD_ANALYZE, 0, VOLT_LO, NOM_NET, NOM_CONV, NOM_TEMP, 0, 1, t);
    // fault number past the end is dropped
    drive_sample(CMD_SET, NUM_FAULTS, NOM_BAT, NOM_NET, NOM_CONV, NOM_TEMP, 0, 0, t);
    drive_sample(CMD_CLEAR, FLT_MODE_CANCEL, NOM_BAT, NOM_NET, NOM_CONV, NOM_TEMP, 0, 0, t);
    t = t + 1;
    drive_sample(CMD_ANALYZE, 0, NOM_BAT, NOM_NET, NOM_CONV, NOM_TEMP, 0, 0, t);
    // discharge-only and heat masks, single clear, then clear all
    drive_sample(CMD_SET, FLT_PAYLOAD_LOCKING, NOM_BAT, NOM_NET, NOM_CONV, NOM_TEMP, 0, 0, t);
    drive_sample(CMD_SET, FLT_PAYLOAD_LOCKED, NOM_BAT, NOM_NET, NOM_CONV, NOM_TEMP, 0, 0, t);
    drive_sample(CMD_SET, FLT_OVERHEAT, NOM_BAT, NOM_NET, NOM_CONV, NOM_TEMP, 0, 0, t);
    drive_sample(CMD_CLEAR, FLT_PAYLOAD_LOCKED, NOM_BAT, NOM_NET, NOM_CONV, NOM_TEMP, 0, 0, t);
    drive_sample(CMD_CLEAR_ALL, FLT_PAYLOAD_SHORT, NOM_BAT, NOM_NET, NOM_CONV, NOM_TEMP,
                 1, 1, t);
    // confirmation across the wrap of the tick counter
    t = {TIME_W{1'b1}} - 9;
    drive_sample(CMD_ANALYZE, 0, NOM_BAT, NOM_NET, NOM_CONV, NOM_TEMP, 0, 0, t);
    t = TIME_W'(CONFIRM_TICKS) - 11;
    drive_sample(CMD_ANALYZE, 0, NOM_BAT, VOLT_LO, NOM_CONV, NOM_TEMP, 0, 0, t);
    t = t + 1;
    drive_sample(CMD_ANALYZE, 0, NOM_BAT, VOLT_LO, NOM_CONV, NOM_TEMP, 0, 0, t);
    tick = t;
    run_random(200);
    drain();

    // Rails: every threshold at its lowest, then at its highest
    load_settings(FLOOR_CFG);
    run_random(120);
    drain();
    load_settings(CEIL_CFG);
    run_random(120);
    drain();

    // Arbitrary thresholds, windows may well be inverted
    load_settings(random_settings());
    run_random(150);
    drain();
    load_settings(random_settings());
    run_random(150);
    drain();

    // Back to the reset values, written this time
    load_settings(RESET_CFG);
    run_random(110);
    drain();

    if (sb.pending() != 0) $error("%0d status beats never arrived", sb.pending());
    $display("Checked %0d status beats under %0d threshold sets.",
             sb.checked, settings_used);
    $display("Voltage faults confirmed %0d times; %0d samples seen under mode cancel.",
             sb.confirms, sb.held_samples);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
